/* rtl/sgw_pkg.sv */
// ----------------------------------------------------------------------------
// sgw_pkg
// Types and codes shared by the scatter-gather page DMA address walker.
// ----------------------------------------------------------------------------
package sgw_pkg;

  localparam int SGW_HANDLE_COUNT = 256;
  localparam int SGW_ADDR_BITS    = 64;
  localparam int QUEUE_DEPTH      = 2;

  localparam logic [2:0] REQ_ADD   = 3'd0;
  localparam logic [2:0] REQ_BEGIN = 3'd1;
  localparam logic [2:0] REQ_RX    = 3'd2;
  localparam logic [2:0] REQ_TX    = 3'd3;
  localparam logic [2:0] REQ_END   = 3'd4;
  localparam logic [2:0] REQ_RESET = 3'd5;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BUSY      = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_EXHAUSTED = 3'd3;
  localparam logic [2:0] ST_TOO_LONG  = 3'd4;

  localparam logic [1:0] CFG_PAGE_SHIFT   = 2'd0;
  localparam logic [1:0] CFG_ADDR_WIDTH   = 2'd1;
  localparam logic [1:0] CFG_TRANSFER_LEN = 2'd2;

  localparam logic [4:0] PAGE_SHIFT_RESET = 5'd12;
  localparam logic [6:0] ADDR_WIDTH_RESET = 7'd64;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [63:0] handle_addr;
    logic [16:0] tx_len;
  } req_t;

  typedef struct packed {
    logic        result_kind;
    logic [63:0] bus_addr;
    logic [16:0] burst_len;
    logic [15:0] buf_offset;
    logic        is_write;
    logic [2:0]  status_code;
    logic [16:0] bytes_moved;
    logic        engine_idle;
    logic        run_finished;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [63:0] handle_addr;
    logic [16:0] tx_len;
  } cmd_t;

endpackage

/* rtl/sgw_front.sv */
// ----------------------------------------------------------------------------
// sgw_front
// Request intake: drops unused selectors and queues commands for the engine.
// ----------------------------------------------------------------------------
module sgw_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  sgw_pkg::req_t req,
  output logic          cmd_valid,
  input  logic          cmd_pop,
  output sgw_pkg::cmd_t cmd
);
  import sgw_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          entries [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [FW-1:0] fill;
  logic          push;
  logic          pop;

  assign req_ready = (fill != FW'(QUEUE_DEPTH));
  assign push      = req_valid && req_ready && (req.req_type <= REQ_RESET);
  assign cmd_valid = (fill != '0);
  assign pop       = cmd_pop && cmd_valid;
  assign cmd       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= '{op: req.req_type, handle_addr: req.handle_addr,
                           tx_len: req.tx_len};
    end
  end

endmodule

/* rtl/sgw_back.sv */
// ----------------------------------------------------------------------------
// sgw_back
// Walk engine: handle table, run state, page split and result register.
// ----------------------------------------------------------------------------
module sgw_back #(
  parameter int HANDLE_COUNT = sgw_pkg::SGW_HANDLE_COUNT,
  parameter int ADDR_BITS    = sgw_pkg::SGW_ADDR_BITS
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_pop,
  input  sgw_pkg::cmd_t cmd,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [31:0]   cfg_data,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output sgw_pkg::rsp_t rsp
);
  import sgw_pkg::*;

  localparam int IW = $clog2(HANDLE_COUNT);
  localparam int CW = $clog2(HANDLE_COUNT + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_LOAD  = 2'd2;
  localparam logic [1:0] S_SPLIT = 2'd3;

  function automatic rsp_t make_rsp(logic kind, logic [63:0] addr, logic [16:0] blen,
                                    logic [15:0] ofs, logic wr, logic [2:0] st,
                                    logic [16:0] moved, logic idle, logic fin,
                                    logic lst);
    rsp_t r;
    r.result_kind  = kind;
    r.bus_addr     = addr;
    r.burst_len    = blen;
    r.buf_offset   = ofs;
    r.is_write     = wr;
    r.status_code  = st;
    r.bytes_moved  = moved;
    r.engine_idle  = idle;
    r.run_finished = fin;
    r.last         = lst;
    return r;
  endfunction

  logic [ADDR_BITS-1:0] handle_mem [HANDLE_COUNT];
  logic [ADDR_BITS-1:0] rd_data;

  logic [1:0]           state, state_next;
  logic [2:0]           op;
  logic [63:0]          haddr;
  logic [16:0]          want, have;
  logic                 too_long;
  logic [CW-1:0]        count, count_next;
  logic [IW-1:0]        pos, pos_next;
  logic [ADDR_BITS-1:0] cur_addr, cur_addr_next;
  logic [31:0]          len_rem, len_rem_next;
  logic                 executing, executing_next;
  logic [4:0]           page_shift, page_shift_next;
  logic [6:0]           addr_width, addr_width_next;
  logic [31:0]          transfer_len, transfer_len_next;

  logic                 load_cmd;
  logic                 mem_we, mem_rd;
  logic [IW-1:0]        rd_idx;
  logic                 emit;
  rsp_t                 emit_data;
  logic                 out_free;

  logic [4:0]           shift_eff;
  logic [16:0]          ps;
  logic [15:0]          ofs;
  logic [16:0]          have_c, want_c, rx_want, rest;
  logic [ADDR_BITS-1:0] mask, addr_fit, addr_split;
  logic [31:0]          len_sub;
  logic [CW-1:0]        pos_inc;

  assign cfg_ready = 1'b1;
  assign cmd_pop   = (state == S_IDLE) && cmd_valid;
  assign load_cmd  = cmd_pop;
  assign out_free  = !rsp_valid || rsp_ready;

  always_comb begin
    for (int i = 0; i < ADDR_BITS; i++) begin
      mask[i] = (i < 16) || (7'(i) < addr_width);
    end
  end

  // page sizing, done while the command is pulled from the queue
  always_comb begin
    shift_eff = (page_shift < 5'd9) ? 5'd9 : ((page_shift > 5'd16) ? 5'd16 : page_shift);
    ps        = 17'd1 << shift_eff;
    ofs       = cur_addr[15:0] & 16'(ps - 17'd1);
    have_c    = ps - {1'b0, ofs};
    rx_want   = (len_rem < {15'd0, ps}) ? len_rem[16:0] : ps;
    want_c    = (cmd.op == REQ_TX) ? cmd.tx_len : rx_want;
  end

  assign rest       = want - have;
  assign addr_fit   = (cur_addr + ADDR_BITS'(want)) & mask;
  assign addr_split = (rd_data + ADDR_BITS'(rest)) & mask;
  assign len_sub    = ({15'd0, want} > len_rem) ? 32'd0 : len_rem - {15'd0, want};
  assign pos_inc    = CW'(pos) + 1'b1;

  always_comb begin
    state_next        = state;
    count_next        = count;
    pos_next          = pos;
    cur_addr_next     = cur_addr;
    len_rem_next      = len_rem;
    executing_next    = executing;
    page_shift_next   = page_shift;
    addr_width_next   = addr_width;
    transfer_len_next = transfer_len;
    mem_we            = 1'b0;
    mem_rd            = 1'b0;
    rd_idx            = '0;
    emit              = 1'b0;
    emit_data         = '0;

    if (cfg_valid) begin
      case (cfg_index)
        CFG_PAGE_SHIFT:   page_shift_next   = cfg_data[4:0];
        CFG_ADDR_WIDTH:   addr_width_next   = cfg_data[6:0];
        CFG_TRANSFER_LEN: transfer_len_next = cfg_data;
        default: ;
      endcase
    end

    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = S_IDLE;
          case (op)
            REQ_ADD: begin
              if (count == CW'(HANDLE_COUNT)) begin
                emit_data = make_rsp(1'b1, '0, '0, '0, 1'b0, ST_FULL, '0,
                                     !executing, len_rem == '0, 1'b1);
              end else begin
                mem_we     = 1'b1;
                count_next = count + 1'b1;
                emit_data  = make_rsp(1'b1, '0, '0, '0, 1'b0, ST_OK, '0,
                                      !executing, len_rem == '0, 1'b1);
              end
            end
            REQ_BEGIN: begin
              len_rem_next   = transfer_len;
              pos_next       = '0;
              executing_next = 1'b1;
              mem_rd         = 1'b1;
              state_next     = S_LOAD;
              emit_data      = make_rsp(1'b1, '0, '0, '0, 1'b0,
                                        executing ? ST_BUSY : ST_OK, '0, 1'b0,
                                        transfer_len == '0, 1'b1);
            end
            REQ_RX, REQ_TX: begin
              if ((op == REQ_TX) && too_long) begin
                emit_data = make_rsp(1'b1, '0, '0, '0, 1'b0, ST_TOO_LONG, '0,
                                     !executing, len_rem == '0, 1'b1);
              end else if (want == '0) begin
                emit_data = make_rsp(1'b1, '0, '0, '0, 1'b0, ST_OK, '0,
                                     !executing, len_rem == '0, 1'b1);
              end else if (want <= have) begin
                cur_addr_next = addr_fit;
                len_rem_next  = len_sub;
                emit_data     = make_rsp(1'b0, 64'(cur_addr), want, '0, op == REQ_TX,
                                         ST_OK, want, !executing, len_sub == '0, 1'b1);
              end else if (pos_inc >= count) begin
                emit_data = make_rsp(1'b1, '0, '0, '0, 1'b0, ST_EXHAUSTED, '0,
                                     !executing, len_rem == '0, 1'b1);
              end else begin
                pos_next     = pos_inc[IW-1:0];
                mem_rd       = 1'b1;
                rd_idx       = pos_inc[IW-1:0];
                len_rem_next = len_sub;
                state_next   = S_SPLIT;
                emit_data    = make_rsp(1'b0, 64'(cur_addr), have, '0, op == REQ_TX,
                                        ST_OK, want, !executing, len_sub == '0, 1'b0);
              end
            end
            REQ_END: begin
              executing_next = 1'b0;
              emit_data      = make_rsp(1'b1, '0, '0, '0, 1'b0, ST_OK, '0, 1'b1,
                                        len_rem == '0, 1'b1);
            end
            REQ_RESET: begin
              executing_next    = 1'b0;
              count_next        = '0;
              transfer_len_next = '0;
              page_shift_next   = PAGE_SHIFT_RESET;
              emit_data         = make_rsp(1'b1, '0, '0, '0, 1'b0, ST_OK, '0, 1'b1,
                                           len_rem == '0, 1'b1);
            end
            default: begin
              emit = 1'b0;
            end
          endcase
        end
      end
      S_LOAD: begin
        // entries at or above the fill count read as cleared
        cur_addr_next = (count != '0) ? rd_data : '0;
        state_next    = S_IDLE;
      end
      S_SPLIT: begin
        if (out_free) begin
          emit          = 1'b1;
          cur_addr_next = addr_split;
          state_next    = S_IDLE;
          emit_data     = make_rsp(1'b0, 64'(rd_data), rest, have[15:0], op == REQ_TX,
                                   ST_OK, want, !executing, len_rem == '0, 1'b1);
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      pos          <= '0;
      cur_addr     <= '0;
      len_rem      <= '0;
      executing    <= 1'b0;
      page_shift   <= PAGE_SHIFT_RESET;
      addr_width   <= ADDR_WIDTH_RESET;
      transfer_len <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      count        <= count_next;
      pos          <= pos_next;
      cur_addr     <= cur_addr_next;
      len_rem      <= len_rem_next;
      executing    <= executing_next;
      page_shift   <= page_shift_next;
      addr_width   <= addr_width_next;
      transfer_len <= transfer_len_next;
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_cmd) begin
      op       <= cmd.op;
      haddr    <= cmd.handle_addr;
      want     <= want_c;
      have     <= have_c;
      too_long <= cmd.tx_len > ps;
    end
    if (emit) begin
      rsp <= emit_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      handle_mem[count[IW-1:0]] <= haddr[ADDR_BITS-1:0] & mask;
    end
    if (mem_rd) begin
      rd_data <= handle_mem[rd_idx];
    end
  end

endmodule

/* rtl/sg_page_dma_address_walker.sv */
// ----------------------------------------------------------------------------
// sg_page_dma_address_walker
// Scatter-gather page DMA address generator with a page handle table.
// ----------------------------------------------------------------------------
// Requests enter a two-entry command queue, so the port keeps taking requests
// while the engine works or a result waits on rsp. The engine pulls a command
// and sizes the page in its idle state, then executes it once the result
// register is free: add, end, reset and non-crossing page transfers finish
// there. Begin also passes through a load state for the registered table
// read of handle 0. A page that crosses its boundary gives two bursts, the
// second burst waiting on the table read of the next handle. Unused selectors
// are taken and dropped with no result. The table needs no clearing pass:
// entries at or above the handle count are never used. Config writes are
// always accepted (cfg_ready is high) and must only be issued while idle.
// ----------------------------------------------------------------------------
module sg_page_dma_address_walker #(
  parameter int HANDLE_COUNT = sgw_pkg::SGW_HANDLE_COUNT,
  parameter int ADDR_BITS    = sgw_pkg::SGW_ADDR_BITS
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  sgw_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output sgw_pkg::rsp_t rsp,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [31:0]   cfg_data
);
  import sgw_pkg::*;

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  sgw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd)
  );

  sgw_back #(
    .HANDLE_COUNT (HANDLE_COUNT),
    .ADDR_BITS    (ADDR_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // first half of a split transaction is always a good burst
  a_split_first_is_burst: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.last |-> !rsp.result_kind && (rsp.status_code == ST_OK))
    else $error("non-final result is not an ok burst");

  a_status_only_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.result_kind |-> (rsp.burst_len == '0) && (rsp.bus_addr == '0)
      && (rsp.bytes_moved == '0))
    else $error("status-only result carries burst fields");

  a_burst_within_total: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.result_kind |-> (rsp.burst_len != '0)
      && (rsp.bytes_moved >= rsp.burst_len))
    else $error("burst length inconsistent with bytes moved");

  a_second_half_offset: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_ready && !rsp.last |=> !rsp_valid || (rsp.last
      && ({1'b0, rsp.buf_offset} + rsp.burst_len == rsp.bytes_moved)))
    else $error("second burst does not complete the page transfer");

endmodule

/* test/sgw_walk_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sgw_walk_checker
// Watches the request, result and register channels of the page DMA address
// walker, keeps its own copy of the handle table and run position, predicts
// the burst and status results of every request and compares them in order.
// ----------------------------------------------------------------------------
module sgw_walk_checker #(
  parameter int HANDLE_COUNT = sgw_pkg::SGW_HANDLE_COUNT,
  parameter int ADDR_BITS    = sgw_pkg::SGW_ADDR_BITS
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_ready,
  input  sgw_pkg::req_t req,
  input  logic          rsp_valid,
  input  logic          rsp_ready,
  input  sgw_pkg::rsp_t rsp,
  input  logic          cfg_valid,
  input  logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [31:0]   cfg_data,
  output int unsigned   errors,
  output int unsigned   pending,
  output int unsigned   checked,
  output int unsigned   bursts
);
  import sgw_pkg::*;

  localparam int SHOW_LIMIT = 100;

  logic [63:0] handles [HANDLE_COUNT];
  int unsigned n_handles;
  int unsigned walk_pos;
  logic [63:0] cur_addr;
  logic [31:0] bytes_left;
  bit          running;
  logic [4:0]  pshift;
  logic [6:0]  awidth;
  logic [31:0] run_len;

  rsp_t        due_rsp [$];
  rsp_t        due;
  int unsigned fails = 0;
  int unsigned shown = 0;
  int unsigned seen = 0;
  int unsigned moves = 0;

  function automatic logic [63:0] width_mask();
    int unsigned w;
    w = 32'(awidth);
    if (w > ADDR_BITS) w = ADDR_BITS;
    if (w < 16) w = 16;
    if (w >= 64) return '1;
    return (64'd1 << w) - 64'd1;
  endfunction

  function automatic int unsigned page_bytes();
    int unsigned s;
    s = 32'(pshift);
    if (s < 9) s = 9;
    if (s > 16) s = 16;
    return 32'd1 << s;
  endfunction

  task automatic queue_result(bit kind, logic [63:0] addr, int unsigned blen,
                              int unsigned ofs, bit wr, logic [2:0] st,
                              int unsigned moved, bit lst);
    rsp_t e;
    e.result_kind  = kind;
    e.bus_addr     = addr;
    e.burst_len    = blen[16:0];
    e.buf_offset   = ofs[15:0];
    e.is_write     = wr;
    e.status_code  = st;
    e.bytes_moved  = moved[16:0];
    e.engine_idle  = !running;
    e.run_finished = (bytes_left == 32'd0);
    e.last         = lst;
    due_rsp.push_back(e);
  endtask

  task automatic reset_model();
    foreach (handles[i]) handles[i] = '0;
    n_handles  = 0;
    walk_pos   = 0;
    cur_addr   = '0;
    bytes_left = '0;
    running    = 1'b0;
    pshift     = PAGE_SHIFT_RESET;
    awidth     = ADDR_WIDTH_RESET;
    run_len    = '0;
  endtask

  // One page of a receive or transmit; a crossing splits into two bursts.
  task automatic move_page(int unsigned want, bit wr);
    int unsigned ps;
    int unsigned ofs;
    int unsigned have;
    int unsigned rest;
    logic [63:0] m;
    logic [63:0] a0;
    logic [63:0] a1;
    ps   = page_bytes();
    ofs  = cur_addr[31:0] & (ps - 1);
    have = ps - ofs;
    m    = width_mask();
    a0   = cur_addr;
    if (want == 0) begin
      queue_result(1'b1, '0, 0, 0, 1'b0, ST_OK, 0, 1'b1);
    end else if (want <= have) begin
      cur_addr   = (a0 + 64'(want)) & m;
      bytes_left = (want > bytes_left) ? 32'd0 : bytes_left - want;
      queue_result(1'b0, a0, want, 0, wr, ST_OK, want, 1'b1);
    end else if (walk_pos + 1 >= n_handles || walk_pos + 1 >= HANDLE_COUNT) begin
      queue_result(1'b1, '0, 0, 0, 1'b0, ST_EXHAUSTED, 0, 1'b1);
    end else begin
      walk_pos++;
      a1         = handles[walk_pos];
      rest       = want - have;
      cur_addr   = (a1 + 64'(rest)) & m;
      bytes_left = (want > bytes_left) ? 32'd0 : bytes_left - want;
      queue_result(1'b0, a0, have, 0, wr, ST_OK, want, 1'b0);
      queue_result(1'b0, a1, rest, have, wr, ST_OK, want, 1'b1);
    end
  endtask

  task automatic walk_request(req_t r);
    int unsigned ps;
    case (r.req_type)
      REQ_ADD: begin
        if (n_handles >= HANDLE_COUNT) begin
          queue_result(1'b1, '0, 0, 0, 1'b0, ST_FULL, 0, 1'b1);
        end else begin
          handles[n_handles] = r.handle_addr & width_mask();
          n_handles++;
          queue_result(1'b1, '0, 0, 0, 1'b0, ST_OK, 0, 1'b1);
        end
      end
      REQ_BEGIN: begin
        bytes_left = run_len;
        cur_addr   = handles[0];
        walk_pos   = 0;
        if (running) begin
          queue_result(1'b1, '0, 0, 0, 1'b0, ST_BUSY, 0, 1'b1);
        end else begin
          running = 1'b1;
          queue_result(1'b1, '0, 0, 0, 1'b0, ST_OK, 0, 1'b1);
        end
      end
      REQ_RX: begin
        ps = page_bytes();
        move_page((bytes_left < ps) ? bytes_left : ps, 1'b0);
      end
      REQ_TX: begin
        if (32'(r.tx_len) > page_bytes()) begin
          queue_result(1'b1, '0, 0, 0, 1'b0, ST_TOO_LONG, 0, 1'b1);
        end else begin
          move_page(32'(r.tx_len), 1'b1);
        end
      end
      REQ_END: begin
        running = 1'b0;
        queue_result(1'b1, '0, 0, 0, 1'b0, ST_OK, 0, 1'b1);
      end
      REQ_RESET: begin
        running   = 1'b0;
        n_handles = 0;
        run_len   = '0;
        pshift    = PAGE_SHIFT_RESET;
        foreach (handles[i]) handles[i] = '0;
        queue_result(1'b1, '0, 0, 0, 1'b0, ST_OK, 0, 1'b1);
      end
      default: ;
    endcase
  endtask

  function automatic int unsigned field_diff(string what, logic [63:0] exp_v,
                                             logic [63:0] act_v);
    if (act_v === exp_v) return 0;
    if (shown < SHOW_LIMIT)
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, exp_v, act_v);
    shown++;
    return 1;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      reset_model();
      due_rsp.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PAGE_SHIFT:   pshift = cfg_data[4:0];
          CFG_ADDR_WIDTH:   awidth = cfg_data[6:0];
          CFG_TRANSFER_LEN: run_len = cfg_data;
          default: ;
        endcase
      end
      if (rsp_valid && rsp_ready) begin
        seen++;
        if (due_rsp.size() == 0) begin
          fails++;
          if (shown < SHOW_LIMIT)
            $display("%0t: result transaction, expected none, got %h", $time, rsp);
          shown++;
        end else begin
          due = due_rsp.pop_front();
          if (due.result_kind == 1'b0) moves++;
          fails += field_diff("result_kind", 64'(due.result_kind), 64'(rsp.result_kind));
          fails += field_diff("bus_addr", due.bus_addr, rsp.bus_addr);
          fails += field_diff("burst_len", 64'(due.burst_len), 64'(rsp.burst_len));
          fails += field_diff("buf_offset", 64'(due.buf_offset), 64'(rsp.buf_offset));
          fails += field_diff("is_write", 64'(due.is_write), 64'(rsp.is_write));
          fails += field_diff("status_code", 64'(due.status_code), 64'(rsp.status_code));
          fails += field_diff("bytes_moved", 64'(due.bytes_moved), 64'(rsp.bytes_moved));
          fails += field_diff("engine_idle", 64'(due.engine_idle), 64'(rsp.engine_idle));
          fails += field_diff("run_finished", 64'(due.run_finished),
                              64'(rsp.run_finished));
          fails += field_diff("last", 64'(due.last), 64'(rsp.last));
        end
      end
      if (req_valid && req_ready) walk_request(req);
    end
    errors  <= fails;
    pending <= due_rsp.size();
    checked <= seen;
    bursts  <= moves;
  end

endmodule

/* test/sg_page_dma_address_walker_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sg_page_dma_address_walker_tb
// Drives handle loads, runs, page receives and transmits and register writes
// into the page DMA address walker with random idling on both channels; the
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module sg_page_dma_address_walker_tb;
  import sgw_pkg::*;

  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam logic [2:0] REQ_SPARE6 = 3'd6;
  localparam logic [2:0] REQ_SPARE7 = 3'd7;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 6;
  localparam int TAIL_CYCLES  = 24;
  localparam int TARGET_ITEMS = 1300;
  localparam int CALM_ITEMS   = 150;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_ready;
  req_t        req = '0;
  logic        rsp_valid;
  logic        rsp_ready = 1'b0;
  rsp_t        rsp;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  int unsigned errors;
  int unsigned pending;
  int unsigned checked;
  int unsigned bursts;
  int unsigned sent = 0;
  int unsigned cfg_writes = 0;
  int unsigned quiet = 0;
  int unsigned stall_left = 0;
  int unsigned stim_shift = 12;
  bit          req_idle = 1'b0;
  bit          rsp_idle = 1'b0;

  always #5 clk = ~clk;

  sg_page_dma_address_walker dut (
    .clk,
    .rst,
    .req_valid,
    .req_ready,
    .req,
    .rsp_valid,
    .rsp_ready,
    .rsp,
    .cfg_valid,
    .cfg_ready,
    .cfg_index,
    .cfg_data
  );

  sgw_walk_checker walk_check (
    .clk,
    .rst,
    .req_valid,
    .req_ready,
    .req,
    .rsp_valid,
    .rsp_ready,
    .rsp,
    .cfg_valid,
    .cfg_ready,
    .cfg_index,
    .cfg_data,
    .errors,
    .pending,
    .checked,
    .bursts
  );

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      rsp_ready  <= (stall_left == 1);
    end else if (rsp_idle && $urandom_range(0, 11) == 0) begin
      stall_left <= $urandom_range(1, 14);
      rsp_ready  <= 1'b0;
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic int unsigned stim_page();
    int unsigned s;
    s = stim_shift;
    if (s < 9) s = 9;
    if (s > 16) s = 16;
    return 32'd1 << s;
  endfunction

  function automatic logic [63:0] pick_handle();
    logic [63:0] a;
    a = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: a = '1;
      1: a = '0;
      2, 3: a = a & ~({32'd0, stim_page()} - 64'd1);
      default: ;
    endcase
    return a;
  endfunction

  function automatic logic [16:0] pick_tx_len();
    int unsigned ps;
    ps = stim_page();
    case ($urandom_range(0, 9))
      0: return 17'd0;
      1: return ps[16:0];
      2: return 17'($urandom_range(ps + 1, 131071));
      3: return 17'($urandom_range(0, 131071));
      default: return 17'($urandom_range(1, ps));
    endcase
  endfunction

  // Valid stays up between back-to-back transactions; gaps only on request.
  task automatic send_item(logic [2:0] op, logic [63:0] haddr, logic [16:0] tlen);
    if (req_idle && $urandom_range(0, 5) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= '{req_type: op, handle_addr: haddr, tx_len: tlen};
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    if (op <= REQ_RESET) sent++;
    if (op == REQ_RESET) stim_shift = 12;
  endtask

  task automatic settle();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_writes++;
  endtask

  task automatic program_regs(logic [31:0] shift_w, logic [31:0] width_w, logic [31:0] len_w);
    write_reg(CFG_PAGE_SHIFT, shift_w);
    write_reg(CFG_ADDR_WIDTH, width_w);
    write_reg(CFG_TRANSFER_LEN, len_w);
    if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED, $urandom);
    cfg_valid  <= 1'b0;
    stim_shift = 32'(shift_w[4:0]);
  endtask

  task automatic program_random();
    logic [31:0] sw;
    logic [31:0] ww;
    logic [31:0] lw;
    case ($urandom_range(0, 4))
      0: sw = 32'd9;
      1: sw = 32'd16;
      2: sw = $urandom_range(0, 31);
      default: sw = $urandom_range(9, 16);
    endcase
    if ($urandom_range(0, 3) == 0) sw = sw | ($urandom & 32'hffff_ffe0);
    case ($urandom_range(0, 4))
      0: ww = 32'd16;
      1: ww = 32'd64;
      2: ww = $urandom_range(0, 127);
      default: ww = $urandom_range(16, 64);
    endcase
    if ($urandom_range(0, 3) == 0) ww = ww | ($urandom & 32'hffff_ff80);
    case ($urandom_range(0, 5))
      0: lw = 32'd0;
      1: lw = 32'hffff_ffff;
      2: lw = $urandom;
      default: lw = $urandom_range(1, 1 << 20);
    endcase
    program_regs(sw, ww, lw);
  endtask

  task automatic page_traffic(int unsigned count);
    int unsigned pick;
    repeat (count) begin
      pick = $urandom_range(0, 19);
      if (pick == 0)
        send_item(REQ_BEGIN, {$urandom, $urandom}, 17'($urandom_range(0, 131071)));
      else if (pick == 1)
        send_item(REQ_ADD, pick_handle(), 17'($urandom_range(0, 131071)));
      else if (pick < 11)
        send_item(REQ_RX, {$urandom, $urandom}, 17'($urandom_range(0, 131071)));
      else send_item(REQ_TX, {$urandom, $urandom}, pick_tx_len());
    end
  endtask

  initial begin
    int unsigned k;
    int unsigned phase;
    bit calm;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    req_idle = 1'b1;
    rsp_idle = 1'b1;
    program_regs(32'd9, 32'd16, 32'd1000);
    send_item(REQ_SPARE6, '1, '1);
    send_item(REQ_SPARE7, '0, '0);
    send_item(REQ_BEGIN, '0, '0);
    send_item(REQ_RX, '0, '0);
    send_item(REQ_ADD, '1, '0);
    send_item(REQ_ADD, '0, '0);
    send_item(REQ_ADD, 64'h1234_5678_9abc_def0, '0);
    send_item(REQ_BEGIN, '0, '0);
    send_item(REQ_BEGIN, '0, '0);
    send_item(REQ_TX, '0, 17'd1);
    send_item(REQ_TX, '0, 17'd0);
    send_item(REQ_TX, '0, 17'd513);
    send_item(REQ_RX, '0, '0);
    send_item(REQ_TX, '0, 17'd512);
    send_item(REQ_TX, '0, 17'h1ffff);
    send_item(REQ_END, '0, '0);
    send_item(REQ_RESET, '0, '0);
    send_item(REQ_BEGIN, '0, '0);
    send_item(REQ_RX, '0, '0);
    settle();
    program_regs(32'd16, 32'd64, 32'hffff_ffff);
    send_item(REQ_ADD, '1, '0);
    send_item(REQ_ADD, '0, '0);
    send_item(REQ_BEGIN, '0, '0);
    send_item(REQ_TX, '0, 17'h10000);
    send_item(REQ_RX, '0, '0);
    send_item(REQ_END, '0, '0);
    settle();

    phase = 0;
    while (sent < TARGET_ITEMS) begin
      calm     = (sent + CALM_ITEMS >= TARGET_ITEMS);
      req_idle = !calm && ($urandom_range(0, 3) != 0);
      rsp_idle = !calm && ($urandom_range(0, 3) != 0);
      phase++;
      if (phase == 4) begin
        // fill the handle table past its end, then walk it
        send_item(REQ_RESET, '0, '0);
        repeat (SGW_HANDLE_COUNT + 3) send_item(REQ_ADD, pick_handle(), '0);
        settle();
        program_random();
        send_item(REQ_BEGIN, '0, '0);
        page_traffic(24);
        send_item(REQ_END, '0, '0);
        settle();
      end else if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(5, 20))
          send_item(3'($urandom_range(0, 7)), pick_handle(),
                    $urandom_range(0, 1) ? pick_tx_len() : 17'($urandom_range(0, 131071)));
        settle();
        program_random();
      end else begin
        if ($urandom_range(0, 2) != 0) send_item(REQ_RESET, {$urandom, $urandom}, pick_tx_len());
        k = $urandom_range(1, 12);
        repeat (k) send_item(REQ_ADD, pick_handle(), 17'($urandom_range(0, 131071)));
        settle();
        program_random();
        send_item(REQ_BEGIN, {$urandom, $urandom}, 17'($urandom_range(0, 131071)));
        page_traffic($urandom_range(2, k + 4));
        if ($urandom_range(0, 9) != 0) send_item(REQ_END, {$urandom, $urandom}, '0);
        settle();
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d requests and %0d register writes across page sizes and address widths.",
             sent, cfg_writes);
    $display("Checked %0d results, %0d of them bus bursts.", checked, bursts);
    if (errors == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
